FILE: rtl/core/slipcrc_pkg.sv
package slipcrc_pkg;

    localparam logic [7:0]  SYNC_BYTE = 8'hC0;
    localparam logic [7:0]  ESC_BYTE  = 8'hDB;
    localparam logic [7:0]  ESC_SYNC  = 8'hDC;
    localparam logic [7:0]  ESC_ESC   = 8'hDD;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;

    // Unescaped positions of the flag and data length bytes, and the
    // frame overhead around the data field.
    localparam int FLAG_INDEX    = 4;
    localparam int LENGTH_INDEX  = 6;
    localparam int DATA_OVERHEAD = 9;
    localparam int CRC_BYTES     = 2;

    localparam logic [8:0] MIN_FRAME_LEN_RST = 9'd9;
    localparam logic [8:0] MAX_FRAME_LEN_RST = 9'd256;
    localparam logic [7:0] MAX_DATA_LEN_RST  = 8'd247;
    localparam logic [2:0] SKIP_CRC_BIT_RST  = 3'd0;

    localparam int OPQ_DEPTH = 4;
    localparam int RESQ_DEPTH = 4;

    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_TOO_SHORT     = 3'd1,
        ST_TOO_LONG      = 3'd2,
        ST_CRC_BAD       = 3'd3,
        ST_DLEN_OVER     = 3'd4,
        ST_DLEN_MISMATCH = 3'd5
    } status_t;

    typedef enum logic {
        KIND_DATA   = 1'b0,
        KIND_STATUS = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        REG_MIN_FRAME_LEN = 2'd0,
        REG_MAX_FRAME_LEN = 2'd1,
        REG_MAX_DATA_LEN  = 2'd2,
        REG_SKIP_CRC_BIT  = 2'd3
    } reg_idx_t;

    // One unit of work for the back end. pre_esc asks for an escape byte
    // ahead of the main action; close ends the frame with a status request.
    typedef struct packed {
        logic       pre_esc;
        logic       close;
        logic [7:0] data;
    } op_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] out_byte;
        status_t    status;
        logic [8:0] frame_length;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [8:0] min_frame_len;
        logic [8:0] max_frame_len;
        logic [7:0] max_data_len;
        logic [2:0] skip_crc_bit;
    } cfg_t;

    localparam int OP_W  = $bits(op_t);
    localparam int RES_W = $bits(result_t);

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

FILE: rtl/core/slipcrc_fifo.sv
module slipcrc_fifo
    import slipcrc_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    // DEPTH must be a power of two so the pointers wrap on their own; the block itself does not enforce it.
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: rtl/core/slipcrc_regs.sv
module slipcrc_regs
    import slipcrc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t     cfg_reg, cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        prdata   = '0;
        unique case (idx)
            REG_MIN_FRAME_LEN:
            begin
                prdata = {23'd0, cfg_reg.min_frame_len};
                if (wr_en)
                begin
                    cfg_next.min_frame_len = pwdata[8:0];
                end
            end
            REG_MAX_FRAME_LEN:
            begin
                prdata = {23'd0, cfg_reg.max_frame_len};
                if (wr_en)
                begin
                    cfg_next.max_frame_len = pwdata[8:0];
                end
            end
            REG_MAX_DATA_LEN:
            begin
                prdata = {24'd0, cfg_reg.max_data_len};
                if (wr_en)
                begin
                    cfg_next.max_data_len = pwdata[7:0];
                end
            end
            REG_SKIP_CRC_BIT:
            begin
                prdata = {29'd0, cfg_reg.skip_crc_bit};
                if (wr_en)
                begin
                    cfg_next.skip_crc_bit = pwdata[2:0];
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_frame_len <= MIN_FRAME_LEN_RST;
            cfg_reg.max_frame_len <= MAX_FRAME_LEN_RST;
            cfg_reg.max_data_len  <= MAX_DATA_LEN_RST;
            cfg_reg.skip_crc_bit  <= SKIP_CRC_BIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: rtl/core/slipcrc_front.sv
module slipcrc_front
    import slipcrc_pkg::*;
#(
    parameter int BUFFER_BYTES = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] rx_byte,
    input  logic       push,
    output logic       full,
    input  logic       op_full,
    output logic       op_wr,
    output op_t        op
);

    localparam int ESC_W = $clog2(BUFFER_BYTES + 1);

    logic             in_frame_reg, in_frame_next;
    logic             esc_pend_reg, esc_pend_next;
    logic [ESC_W-1:0] esc_cnt_reg, esc_cnt_next;
    logic             accept;

    assign full   = op_full;
    assign accept = push && !op_full;

    always_comb
    begin
        in_frame_next = in_frame_reg;
        esc_pend_next = esc_pend_reg;
        esc_cnt_next  = esc_cnt_reg;
        op_wr         = 1'b0;
        op            = '{pre_esc: 1'b0, close: 1'b0, data: rx_byte};
        if (accept)
        begin
            priority if (!in_frame_reg)
            begin
                if (rx_byte == SYNC_BYTE)
                begin
                    in_frame_next = 1'b1;
                    esc_pend_next = 1'b0;
                    esc_cnt_next  = '0;
                end
            end
            else if (rx_byte == SYNC_BYTE)
            begin
                // An empty frame closes silently.
                if (esc_cnt_reg != '0)
                begin
                    op_wr = 1'b1;
                    op    = '{pre_esc: esc_pend_reg, close: 1'b1, data: 8'h00};
                end
                esc_pend_next = 1'b0;
                esc_cnt_next  = '0;
            end
            else if (esc_cnt_reg < ESC_W'(BUFFER_BYTES))
            begin
                esc_cnt_next = esc_cnt_reg + 1'b1;
                if (esc_pend_reg)
                begin
                    op_wr = 1'b1;
                    priority if (rx_byte == ESC_SYNC)
                    begin
                        esc_pend_next = 1'b0;
                        op.data       = SYNC_BYTE;
                    end
                    else if (rx_byte == ESC_ESC)
                    begin
                        esc_pend_next = 1'b0;
                        op.data       = ESC_BYTE;
                    end
                    else if (rx_byte == ESC_BYTE)
                    begin
                        // The earlier escape goes out plain; this one stays pending.
                        op.data = ESC_BYTE;
                    end
                    else
                    begin
                        esc_pend_next = 1'b0;
                        op.pre_esc    = 1'b1;
                    end
                end
                else if (rx_byte == ESC_BYTE)
                begin
                    esc_pend_next = 1'b1;
                end
                else
                begin
                    op_wr = 1'b1;
                end
            end
            else
            begin
                // Bytes past the buffer limit are dropped.
                op_wr = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            esc_pend_reg <= 1'b0;
            esc_cnt_reg  <= '0;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            esc_pend_reg <= esc_pend_next;
            esc_cnt_reg  <= esc_cnt_next;
        end
    end

endmodule

FILE: rtl/core/slipcrc_back.sv
module slipcrc_back
    import slipcrc_pkg::*;
#(
    parameter int BUFFER_BYTES = 256
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    op_empty,
    input  op_t     op,
    output logic    op_rd,
    input  logic    res_full,
    output logic    res_wr,
    output result_t res
);

    // A trailing escape is already counted by the front end, so the raw count stays within the buffer limit.
    localparam int RAW_W = $clog2(BUFFER_BYTES + 2);
    localparam int CMP_W = (RAW_W > 9) ? RAW_W : 9;

    logic [RAW_W-1:0] raw_cnt_reg, raw_cnt_next;
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       tail0_reg, tail0_next;
    logic [7:0]       tail1_reg, tail1_next;
    logic [7:0]       flag_reg, flag_next;
    logic [7:0]       dlen_reg, dlen_next;
    logic             phase_reg, phase_next;

    logic             first_step;
    logic [7:0]       raw_byte;
    logic [CMP_W-1:0] len_ext;
    logic [CMP_W-1:0] len_minus;
    status_t          frame_st;

    assign first_step = !phase_reg && op.pre_esc;
    assign raw_byte   = first_step ? ESC_BYTE : op.data;
    assign len_ext    = CMP_W'(raw_cnt_reg);
    assign len_minus  = len_ext - CMP_W'(DATA_OVERHEAD);

    always_comb
    begin
        priority if (len_ext < CMP_W'(cfg.min_frame_len))
        begin
            frame_st = ST_TOO_SHORT;
        end
        else if (len_ext > CMP_W'(cfg.max_frame_len))
        begin
            frame_st = ST_TOO_LONG;
        end
        else if (!flag_reg[cfg.skip_crc_bit]
                 && ((len_ext < CMP_W'(CRC_BYTES)) || ({tail0_reg, tail1_reg} != crc_reg)))
        begin
            frame_st = ST_CRC_BAD;
        end
        else if (dlen_reg > cfg.max_data_len)
        begin
            frame_st = ST_DLEN_OVER;
        end
        else if ((len_ext < CMP_W'(DATA_OVERHEAD)) || (CMP_W'(dlen_reg) != len_minus))
        begin
            frame_st = ST_DLEN_MISMATCH;
        end
        else
        begin
            frame_st = ST_OK;
        end
    end

    always_comb
    begin
        raw_cnt_next = raw_cnt_reg;
        crc_next     = crc_reg;
        tail0_next   = tail0_reg;
        tail1_next   = tail1_reg;
        flag_next    = flag_reg;
        dlen_next    = dlen_reg;
        phase_next   = phase_reg;
        op_rd        = 1'b0;
        res_wr       = 1'b0;
        res          = '{kind: KIND_DATA, out_byte: 8'h00, status: ST_OK,
                         frame_length: 9'd0, last: 1'b0};
        if (!op_empty && !res_full)
        begin
            res_wr   = 1'b1;
            res.last = !first_step;
            if (first_step)
            begin
                phase_next = 1'b1;
            end
            else
            begin
                phase_next = 1'b0;
                op_rd      = 1'b1;
            end

            if (!first_step && op.close)
            begin
                res.kind         = KIND_STATUS;
                res.status       = frame_st;
                res.frame_length = len_ext[8:0];
                raw_cnt_next     = '0;
                crc_next         = CRC_INIT;
                tail0_next       = 8'h00;
                tail1_next       = 8'h00;
                flag_next        = 8'h00;
                dlen_next        = 8'h00;
            end
            else
            begin
                res.out_byte = raw_byte;
                // The CRC runs two bytes behind so the trailing CRC is left out.
                if (raw_cnt_reg >= RAW_W'(CRC_BYTES))
                begin
                    crc_next = crc_feed(crc_reg, tail1_reg);
                end
                tail1_next = tail0_reg;
                tail0_next = raw_byte;
                if (raw_cnt_reg == RAW_W'(FLAG_INDEX))
                begin
                    flag_next = raw_byte;
                end
                if (raw_cnt_reg == RAW_W'(LENGTH_INDEX))
                begin
                    dlen_next = raw_byte;
                end
                raw_cnt_next = raw_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_cnt_reg <= '0;
            crc_reg     <= CRC_INIT;
            tail0_reg   <= 8'h00;
            tail1_reg   <= 8'h00;
            flag_reg    <= 8'h00;
            dlen_reg    <= 8'h00;
            phase_reg   <= 1'b0;
        end
        else
        begin
            raw_cnt_reg <= raw_cnt_next;
            crc_reg     <= crc_next;
            tail0_reg   <= tail0_next;
            tail1_reg   <= tail1_next;
            flag_reg    <= flag_next;
            dlen_reg    <= dlen_next;
            phase_reg   <= phase_next;
        end
    end

endmodule

FILE: rtl/core/slip_crc16_frame_receiver_top.sv
// Channel   | Direction | Handshake              | Payload
// ----------+-----------+------------------------+------------------------------------------
// input     | in        | push / full            | rx_byte
// result    | out       | empty / pop            | kind, out_byte, status, frame_length, last
// config    | in        | psel, penable, pwrite  | paddr, pwdata, prdata, pready
//
// One line byte is accepted per cycle while the 4-entry work queue has room.
// The back end writes one result per cycle into a 4-entry result queue while it
// has room, so a byte that yields two results (escape followed by a plain byte,
// or a pending escape at frame close) stays in the work queue until both are written.
// A result can be popped in the cycle after the back end writes it.
// Reset clears both queues and all framing state; no clearing pass is needed.
// Either side may stall freely; the queues absorb the difference.
module slip_crc16_frame_receiver_top
    import slipcrc_pkg::*;
#(
    parameter int BUFFER_BYTES = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  rx_byte,
    input  logic        push,
    output logic        full,
    output logic        kind,
    output logic [7:0]  out_byte,
    output logic [2:0]  status,
    output logic [8:0]  frame_length,
    output logic        last,
    output logic        empty,
    input  logic        pop,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t             cfg;
    op_t              op_in;
    op_t              op_out;
    logic             op_wr;
    logic             op_full;
    logic             op_rd;
    logic             op_empty;
    logic [OP_W-1:0]  op_rd_data;
    result_t          res_in;
    result_t          res_out;
    logic             res_wr;
    logic             res_full;
    logic [RES_W-1:0] res_rd_data;

    slipcrc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    slipcrc_front #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx_byte (rx_byte),
        .push    (push),
        .full    (full),
        .op_full (op_full),
        .op_wr   (op_wr),
        .op      (op_in)
    );

    slipcrc_fifo #(
        .WIDTH (OP_W),
        .DEPTH (OPQ_DEPTH)
    ) u_op_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (op_wr),
        .wr_data (op_in),
        .full    (op_full),
        .rd_en   (op_rd),
        .rd_data (op_rd_data),
        .empty   (op_empty)
    );

    assign op_out = op_t'(op_rd_data);

    slipcrc_back #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .op_empty (op_empty),
        .op       (op_out),
        .op_rd    (op_rd),
        .res_full (res_full),
        .res_wr   (res_wr),
        .res      (res_in)
    );

    slipcrc_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RESQ_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_wr),
        .wr_data (res_in),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_rd_data),
        .empty   (empty)
    );

    assign res_out      = result_t'(res_rd_data);
    assign kind         = res_out.kind;
    assign out_byte     = res_out.out_byte;
    assign status       = res_out.status;
    assign frame_length = res_out.frame_length;
    assign last         = res_out.last;

endmodule
